// ===== src/assert_macros.svh =====
// Assertion helpers shared by the voter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define PCV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define PCV_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== src/pcv_pkg.sv =====
package pcv_pkg;

   // Fixed field widths of the transaction payloads.
   localparam int POS_W   = 12;
   localparam int OFF_W   = 8;
   localparam int CODE_W  = 3;
   localparam int COV_W   = 8;

   localparam logic       FUNC_LOAD   = 1'b0;
   localparam logic       FUNC_EMIT   = 1'b1;
   localparam logic [2:0] CODE_MASKED = 3'd6;
   localparam logic [2:0] VOTE_GAP    = 3'd4;
   localparam int         NUM_VOTES   = 5;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_EMIT,
      CMD_EMIT_NONE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [POS_W-1:0]    pos;
      logic [OFF_W-1:0]    offset;
      logic [CODE_W-1:0]   lane;
      logic                cov_inc;
      logic                vote_inc;
   } cmd_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_WR,
      ST_EMIT_EVAL,
      ST_EMIT_FLUSH
   } back_state_type;

endpackage

// ===== src/pcv_front.sv =====
`include "assert_macros.svh"

module pcv_front #(
   parameter int POSITIONS    = 4096,
   parameter int OFFSET_SLOTS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [pcv_pkg::POS_W-1:0]     req_position,
   input  logic [pcv_pkg::OFF_W-1:0]     req_insert_offset,
   input  logic [pcv_pkg::CODE_W-1:0]    req_base_code,
   output logic                          q_valid,
   output pcv_pkg::cmd_type              q_cmd,
   input  pcv_pkg::back_ctl_type         back_ctl
);

   pcv_pkg::cmd_type                  queue_ff [pcv_pkg::QUEUE_DEPTH];
   logic [pcv_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pcv_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pcv_pkg::QUEUE_PTR_W:0]     count_ff, count_in;

   logic              accept;
   logic              keep;
   logic              in_range;
   logic              slot_ok;
   pcv_pkg::cmd_type  cls;

   // classify
   always_comb begin
      in_range     = 32'(req_position) < 32'(POSITIONS);
      slot_ok      = 32'(req_insert_offset) < 32'(OFFSET_SLOTS);
      cls.pos      = req_position;
      cls.offset   = req_insert_offset;
      cls.lane     = req_base_code;
      cls.cov_inc  = (req_insert_offset == '0) && (req_base_code != pcv_pkg::CODE_MASKED);
      cls.vote_inc = 32'(req_base_code) < 32'(pcv_pkg::NUM_VOTES);
      if (req_func == pcv_pkg::FUNC_EMIT) begin
         cls.kind = in_range ? pcv_pkg::CMD_EMIT : pcv_pkg::CMD_EMIT_NONE;
         keep     = 1'b1;
      end else begin
         cls.kind = pcv_pkg::CMD_LOAD;
         keep     = in_range && slot_ok && (cls.cov_inc || cls.vote_inc);
      end
   end

   assign req_ready = (count_ff != (pcv_pkg::QUEUE_PTR_W+1)'(pcv_pkg::QUEUE_DEPTH))
                      && !back_ctl.clearing;
   assign accept    = req_valid && req_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && keep) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (back_ctl.pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (pcv_pkg::QUEUE_PTR_W+1)'(accept && keep)
                 - (pcv_pkg::QUEUE_PTR_W+1)'(back_ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

   assign q_valid = count_ff != '0;
   assign q_cmd   = queue_ff[rd_ptr_ff];

   `PCV_ASSERT(a_queue_bound, clock, reset,
      count_ff <= (pcv_pkg::QUEUE_PTR_W+1)'(pcv_pkg::QUEUE_DEPTH), "queue overfilled")

endmodule

// ===== src/pcv_back.sv =====
`include "assert_macros.svh"

module pcv_back #(
   parameter int POSITIONS    = 4096,
   parameter int OFFSET_SLOTS = 8,
   parameter int COUNT_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  pcv_pkg::cmd_type              q_cmd,
   output pcv_pkg::back_ctl_type         back_ctl,
   input  logic [pcv_pkg::COV_W-1:0]     min_coverage,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_called,
   output logic [1:0]                    rsp_called_base,
   output logic                          rsp_low_coverage,
   output logic [pcv_pkg::COV_W-1:0]     rsp_effective_coverage,
   output logic                          rsp_last
);

   localparam int PW      = $clog2(POSITIONS);
   localparam int SW      = (OFFSET_SLOTS > 1) ? $clog2(OFFSET_SLOTS) : 1;
   localparam int AW      = PW + SW;
   localparam int VDEPTH  = POSITIONS * (1 << SW);
   localparam int ROW_W   = pcv_pkg::NUM_VOTES * COUNT_BITS;
   localparam int CEXT_W  = (COUNT_BITS > pcv_pkg::COV_W) ? COUNT_BITS : pcv_pkg::COV_W;

   // vote rows addressed {position, slot}; coverage addressed by position
   logic [ROW_W-1:0]      vote_ram [VDEPTH];
   logic [COUNT_BITS-1:0] cov_ram  [POSITIONS];

   logic [ROW_W-1:0]      vote_rd_ff;
   logic [COUNT_BITS-1:0] cov_rd_ff;

   pcv_pkg::back_state_type state_ff, state_in;
   pcv_pkg::cmd_type        cmd_ff, cmd_in;
   logic [SW-1:0]           slot_ff, slot_in;
   logic [COUNT_BITS-1:0]   cov_ff, cov_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [1:0]              pend_base_ff, pend_base_in;
   logic [AW-1:0]           clr_ff, clr_in;

   logic                    rsp_valid_ff;
   logic                    rsp_called_ff, rsp_low_ff, rsp_last_ff;
   logic [1:0]              rsp_base_ff;
   logic [pcv_pkg::COV_W-1:0] rsp_cov_ff;

   logic                  vote_re, vote_we, cov_re, cov_we;
   logic [AW-1:0]         vote_raddr, vote_waddr;
   logic [ROW_W-1:0]      vote_wdata;
   logic [PW-1:0]         cov_raddr, cov_waddr;
   logic [COUNT_BITS-1:0] cov_wdata;

   logic                  out_push, out_free;
   logic                  out_called, out_low, out_last;
   logic [1:0]            out_base;
   logic [CEXT_W-1:0]     cov_ext;
   logic [pcv_pkg::COV_W-1:0] cov_sat;
   logic                  cov_low;

   logic [COUNT_BITS-1:0] cov_cur;
   logic [COUNT_BITS-1:0] best;
   logic [2:0]            best_idx;
   logic                  call;
   logic                  last_slot;
   logic [ROW_W-1:0]      inc_row;
   logic [COUNT_BITS-1:0] inc_cov;
   logic [PW-1:0]         q_pos, c_pos;

   assign q_pos     = PW'(q_cmd.pos);
   assign c_pos     = PW'(cmd_ff.pos);
   assign last_slot = 32'(slot_ff) == 32'(OFFSET_SLOTS - 1);
   assign cov_cur   = (slot_ff == '0) ? cov_rd_ff : cov_ff;

   // first strict maximum in A, C, G, T, gap order
   always_comb begin
      best     = '0;
      best_idx = '0;
      for (int v = 0; v < pcv_pkg::NUM_VOTES; v++) begin
         if (vote_rd_ff[v*COUNT_BITS +: COUNT_BITS] > best) begin
            best     = vote_rd_ff[v*COUNT_BITS +: COUNT_BITS];
            best_idx = 3'(v);
         end
      end
      call = ({best, 1'b0} > {1'b0, cov_cur}) && (best_idx != pcv_pkg::VOTE_GAP);
   end

   // saturating increment of the addressed lane and of coverage
   always_comb begin
      inc_row = vote_rd_ff;
      for (int v = 0; v < pcv_pkg::NUM_VOTES; v++) begin
         if (cmd_ff.vote_inc && (cmd_ff.lane == 3'(v))
             && (vote_rd_ff[v*COUNT_BITS +: COUNT_BITS] != '1)) begin
            inc_row[v*COUNT_BITS +: COUNT_BITS] = vote_rd_ff[v*COUNT_BITS +: COUNT_BITS] + 1'b1;
         end
      end
      inc_cov = (cmd_ff.cov_inc && (cov_rd_ff != '1)) ? cov_rd_ff + 1'b1 : cov_rd_ff;
   end

   always_comb begin
      cov_ext = CEXT_W'(cov_ff);
      cov_sat = (cov_ext > CEXT_W'(8'hFF)) ? 8'hFF : cov_ext[pcv_pkg::COV_W-1:0];
      cov_low = cov_ext <= CEXT_W'(min_coverage);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      cov_in        = cov_ff;
      pend_valid_in = pend_valid_ff;
      pend_base_in  = pend_base_ff;
      clr_in        = clr_ff;
      back_ctl      = '0;
      vote_re       = 1'b0;
      vote_raddr    = {q_pos, SW'(q_cmd.offset)};
      vote_we       = 1'b0;
      vote_waddr    = {c_pos, SW'(cmd_ff.offset)};
      vote_wdata    = inc_row;
      cov_re        = 1'b0;
      cov_raddr     = q_pos;
      cov_we        = 1'b0;
      cov_waddr     = c_pos;
      cov_wdata     = inc_cov;
      out_push      = 1'b0;
      out_called    = 1'b0;
      out_base      = '0;
      out_low       = 1'b0;
      out_last      = 1'b0;
      unique case (state_ff)
         pcv_pkg::ST_CLEAR: begin
            back_ctl.clearing = 1'b1;
            vote_we    = 1'b1;
            vote_waddr = clr_ff;
            vote_wdata = '0;
            cov_we     = 1'b1;
            cov_waddr  = clr_ff[AW-1 -: PW];
            cov_wdata  = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == AW'(VDEPTH - 1)) begin
               state_in = pcv_pkg::ST_IDLE;
            end
         end
         pcv_pkg::ST_IDLE: begin
            if (q_valid) begin
               back_ctl.pop  = 1'b1;
               cmd_in        = q_cmd;
               slot_in       = '0;
               pend_valid_in = 1'b0;
               unique case (q_cmd.kind)
                  pcv_pkg::CMD_LOAD: begin
                     vote_re  = 1'b1;
                     cov_re   = 1'b1;
                     state_in = pcv_pkg::ST_LOAD_WR;
                  end
                  pcv_pkg::CMD_EMIT: begin
                     vote_re    = 1'b1;
                     vote_raddr = {q_pos, SW'(0)};
                     cov_re     = 1'b1;
                     state_in   = pcv_pkg::ST_EMIT_EVAL;
                  end
                  default: begin
                     cov_in   = '0;
                     state_in = pcv_pkg::ST_EMIT_FLUSH;
                  end
               endcase
            end
         end
         pcv_pkg::ST_LOAD_WR: begin
            vote_we  = cmd_ff.vote_inc;
            cov_we   = cmd_ff.cov_inc;
            state_in = pcv_pkg::ST_IDLE;
         end
         pcv_pkg::ST_EMIT_EVAL: begin
            if (!(call && pend_valid_ff && !out_free)) begin
               vote_we    = 1'b1;
               vote_waddr = {c_pos, slot_ff};
               vote_wdata = '0;
               if (slot_ff == '0) begin
                  cov_we    = 1'b1;
                  cov_wdata = '0;
                  cov_in    = cov_rd_ff;
               end
               if (call) begin
                  // a later call exists, so the held one is not last
                  out_push      = pend_valid_ff;
                  out_called    = 1'b1;
                  out_base      = pend_base_ff;
                  out_low       = cov_low;
                  pend_valid_in = 1'b1;
                  pend_base_in  = best_idx[1:0];
               end
               if (last_slot) begin
                  state_in = pcv_pkg::ST_EMIT_FLUSH;
               end else begin
                  slot_in    = slot_ff + 1'b1;
                  vote_re    = 1'b1;
                  vote_raddr = {c_pos, slot_ff + 1'b1};
               end
            end
         end
         pcv_pkg::ST_EMIT_FLUSH: begin
            if (out_free) begin
               out_push   = 1'b1;
               out_called = pend_valid_ff;
               out_base   = pend_valid_ff ? pend_base_ff : 2'd0;
               out_low    = pend_valid_ff && cov_low;
               out_last   = 1'b1;
               state_in   = pcv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcv_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pcv_pkg::ST_CLEAR;
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
         if (out_push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      slot_ff      <= slot_in;
      cov_ff       <= cov_in;
      pend_base_ff <= pend_base_in;
      if (out_push) begin
         rsp_called_ff <= out_called;
         rsp_base_ff   <= out_base;
         rsp_low_ff    <= out_low;
         rsp_cov_ff    <= cov_sat;
         rsp_last_ff   <= out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (vote_we) begin
         vote_ram[vote_waddr] <= vote_wdata;
      end
      if (vote_re) begin
         vote_rd_ff <= vote_ram[vote_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cov_we) begin
         cov_ram[cov_waddr] <= cov_wdata;
      end
      if (cov_re) begin
         cov_rd_ff <= cov_ram[cov_raddr];
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_called             = rsp_called_ff;
   assign rsp_called_base        = rsp_base_ff;
   assign rsp_low_coverage       = rsp_low_ff;
   assign rsp_effective_coverage = rsp_cov_ff;
   assign rsp_last               = rsp_last_ff;

   `PCV_ASSERT(a_push_free, clock, reset, out_push |-> out_free,
      "result pushed into occupied output register")
   `PCV_ASSERT(a_pop_idle, clock, reset,
      back_ctl.pop |-> (state_ff == pcv_pkg::ST_IDLE && q_valid), "pop outside idle")
   `PCV_NEVER(a_no_rsp_clear, clock, reset,
      state_ff == pcv_pkg::ST_CLEAR && rsp_valid_ff, "result during clearing pass")
   `PCV_ASSERT(a_slot_range, clock, reset,
      state_ff == pcv_pkg::ST_EMIT_EVAL |-> 32'(slot_ff) < 32'(OFFSET_SLOTS),
      "emit slot out of range")

endmodule

// ===== src/pileup_consensus_voter_top.sv =====
// Load transaction: registered into the queue, then read by the back engine in ST_IDLE
//   and written back (one vote row and coverage) in ST_LOAD_WR before the next command.
// Emit transaction: the back engine reads slot 0 in ST_IDLE, walks the slots in
//   ST_EMIT_EVAL, and pushes the last result from ST_EMIT_FLUSH once the output is free.
// Reset (synchronous, active high) starts a clearing pass over POSITIONS * 2^ceil(log2
//   OFFSET_SLOTS) vote rows (32768 at defaults) with req_ready low; csr writes work always.
module pileup_consensus_voter_top #(
   parameter int POSITIONS    = 4096,
   parameter int OFFSET_SLOTS = 8,
   parameter int COUNT_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [pcv_pkg::POS_W-1:0]     req_position,
   input  logic [pcv_pkg::OFF_W-1:0]     req_insert_offset,
   input  logic [pcv_pkg::CODE_W-1:0]    req_base_code,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_called,
   output logic [1:0]                    rsp_called_base,
   output logic                          rsp_low_coverage,
   output logic [pcv_pkg::COV_W-1:0]     rsp_effective_coverage,
   output logic                          rsp_last,
   // control register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pcv_pkg::COV_W-1:0]     csr_min_coverage
);

   // The front classifies each request transaction: loads that would touch
   // nothing (position or offset out of range, a masked base, or an other
   // base off the template slot) are dropped here; emits for an out-of-range
   // position are tagged so the back engine answers with a single no-call
   // result.
   //
   // The back engine owns both count memories. Every memory read is
   // registered; a load reads in ST_IDLE, then writes back in ST_LOAD_WR.
   // An emit walks one offset slot per cycle unless a held call waits on
   // a full output register: it picks the winner from the registered row
   // of the last read, zeroes that row, and launches the next slot's read.
   // One call is held back so the last flag is set once no later slot calls.

   logic [pcv_pkg::COV_W-1:0] min_cov_ff, min_cov_in;
   logic                      q_valid;
   pcv_pkg::cmd_type          q_cmd;
   pcv_pkg::back_ctl_type     back_ctl;

   // Config is single-register and always writable; software must only write
   // it while no emit is in flight, a rule the block itself does not enforce.
   assign csr_ready  = 1'b1;
   assign min_cov_in = (csr_valid && csr_ready) ? csr_min_coverage : min_cov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_cov_ff <= '0;
      end else begin
         min_cov_ff <= min_cov_in;
      end
   end

   pcv_front #(
      .POSITIONS    (POSITIONS),
      .OFFSET_SLOTS (OFFSET_SLOTS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_position      (req_position),
      .req_insert_offset (req_insert_offset),
      .req_base_code     (req_base_code),
      .q_valid           (q_valid),
      .q_cmd             (q_cmd),
      .back_ctl          (back_ctl)
   );

   // Response register lives in the back engine; the queue keeps accepting
   // while a finished result waits on rsp_ready.
   pcv_back #(
      .POSITIONS    (POSITIONS),
      .OFFSET_SLOTS (OFFSET_SLOTS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_valid                (q_valid),
      .q_cmd                  (q_cmd),
      .back_ctl               (back_ctl),
      .min_coverage           (min_cov_ff),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_called             (rsp_called),
      .rsp_called_base        (rsp_called_base),
      .rsp_low_coverage       (rsp_low_coverage),
      .rsp_effective_coverage (rsp_effective_coverage),
      .rsp_last               (rsp_last)
   );

endmodule
